// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file hwts_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hwts_pkg.sv =====
// Package for the host window traffic statistics core: defaults, field widths,
// sequencer state codes and the divider control bundle. Depends on nothing.
package hwts_pkg;

    localparam int SERVICE_COUNT_DEF = 128;
    localparam int COUNTER_BITS_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // Width of the service field on the request channel.
    localparam int SERVICE_BITS = 7;
    localparam int SERVICE_SPAN = 2 ** SERVICE_BITS;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_CALC  = 6'b001000,
        S_DIV   = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
    } div_ctrl_t;

endpackage

// ===== src/hwts_if.sv =====
// Request and result channel interfaces of the host window traffic stats core.
// Depends on hwts_pkg for widths and defaults.
interface hwts_evt_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic [hwts_pkg::SERVICE_BITS-1:0] service;
    logic                              syn_error;
    logic                              rej_error;

    modport source (output valid, cmd, service, syn_error, rej_error, input ready);
    modport sink   (input valid, cmd, service, syn_error, rej_error, output ready);
endinterface

interface hwts_res_if #(
    parameter int CounterBits  = hwts_pkg::COUNTER_BITS_DEF,
    parameter int FractionBits = hwts_pkg::FRACTION_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [CounterBits-1:0]  count_before;
    logic [FractionBits:0]   syn_error_rate;
    logic [FractionBits:0]   rej_error_rate;
    logic [FractionBits:0]   same_service_rate;
    logic [FractionBits:0]   diff_service_rate;
    logic [CounterBits-1:0]  same_service_count;
    logic                    window_empty;

    modport source (
        output valid, count_before, syn_error_rate, rej_error_rate,
               same_service_rate, diff_service_rate, same_service_count, window_empty,
        input  ready
    );
    modport sink (
        input  valid, count_before, syn_error_rate, rej_error_rate,
               same_service_rate, diff_service_rate, same_service_count, window_empty,
        output ready
    );
endinterface

// ===== src/hwts_div.sv =====
// One bit-serial restoring divider lane: rate = min(num * 2^F / den, 2^F).
// Depends on hwts_pkg for the control bundle.
module hwts_div #(
    parameter int CounterBits  = hwts_pkg::COUNTER_BITS_DEF,
    parameter int FractionBits = hwts_pkg::FRACTION_BITS_DEF
) (
    input  logic                  clk,
    input  hwts_pkg::div_ctrl_t   ctrl,
    input  logic [CounterBits-1:0] num,
    input  logic [CounterBits-1:0] den,
    output logic [FractionBits:0]  rate
);

    localparam logic [FractionBits:0] RateOne = (FractionBits + 1)'(1) << FractionBits;

    logic [CounterBits-1:0]  rem_reg,  rem_next;
    logic [FractionBits-1:0] quot_reg, quot_next;
    logic                    sat_reg,  sat_next;
    logic [CounterBits:0]    rem_dbl;
    logic [CounterBits:0]    rem_sub;
    logic                    ge;

    // Remainder stays below den once started, so its double fits one extra bit.
    assign rem_dbl = {rem_reg, 1'b0};
    assign ge      = (rem_dbl >= {1'b0, den});
    assign rem_sub = rem_dbl - {1'b0, den};

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        sat_next  = sat_reg;
        if (ctrl.start)
        begin
            rem_next  = num;
            quot_next = '0;
            sat_next  = (num >= den);
        end
        else if (ctrl.step)
        begin
            rem_next  = ge ? rem_sub[CounterBits-1:0] : rem_dbl[CounterBits-1:0];
            quot_next = {quot_reg[FractionBits-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        sat_reg  <= sat_next;
    end

    assign rate = sat_reg ? RateOne : {1'b0, quot_reg};

endmodule

// ===== src/host_window_traffic_stats_core.sv =====
// Host window traffic statistics core: per-host connection counters and rates.
// Depends on hwts_pkg, hwts_if (hwts_evt_if, hwts_res_if) and hwts_div.
//
//  port | direction | contents
//  -----+-----------+---------------------------------------------------------
//  evt  | in        | cmd (add/remove), service, syn_error, rej_error
//  res  | out       | count_before, four Q1.F rates, same_service_count, empty
//
//  An add request passes through the read, calc, divide and finish states
//  before the next one is accepted; the length of the divide state is set by
//  the three bit-serial divider lanes that produce one quotient bit each cycle.
//  A remove request skips the divide state. After reset the per-service memory
//  is cleared one entry a cycle, so evt is not ready until that sweep ends. A
//  stalled result is held in the output register while the next request is
//  read and divided; the finished result then waits until that register is free.
module host_window_traffic_stats_core #(
    parameter int ServiceCount = hwts_pkg::SERVICE_COUNT_DEF,
    parameter int CounterBits  = hwts_pkg::COUNTER_BITS_DEF,
    parameter int FractionBits = hwts_pkg::FRACTION_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    hwts_evt_if.sink        evt,
    hwts_res_if.source      res
);

    localparam int IdxBits  = $clog2(ServiceCount);
    localparam int StepBits = $clog2(FractionBits + 1);
    localparam int RateBits = FractionBits + 1;
    localparam logic [RateBits-1:0] RateOne = RateBits'(1) << FractionBits;
    localparam logic [IdxBits-1:0]  LastIdx = IdxBits'(ServiceCount - 1);
    localparam logic [StepBits-1:0] LastStep = StepBits'(FractionBits - 1);

    // Service numbers wrap modulo ServiceCount; the table is fixed at elaboration.
    logic [IdxBits-1:0] wrap_tab [hwts_pkg::SERVICE_SPAN];

    for (genvar g = 0; g < hwts_pkg::SERVICE_SPAN; g++)
    begin : g_wrap
        assign wrap_tab[g] = IdxBits'(g % ServiceCount);
    end

    // Per-service counters.
    logic [CounterBits-1:0] svc_mem [ServiceCount];

    hwts_pkg::state_t       state_reg,   state_next;
    logic [IdxBits-1:0]     clr_reg,     clr_next;
    logic [StepBits-1:0]    step_reg,    step_next;
    logic [CounterBits-1:0] total_reg,   total_next;
    logic [CounterBits-1:0] syn_cnt_reg, syn_cnt_next;
    logic [CounterBits-1:0] rej_cnt_reg, rej_cnt_next;
    logic                   res_valid_reg, res_valid_next;

    // Request payload and working values.
    logic                   cmd_reg;
    logic                   syn_reg;
    logic                   rej_reg;
    logic [IdxBits-1:0]     idx_reg;
    logic [CounterBits-1:0] rd_reg;
    logic [CounterBits-1:0] den_reg;
    logic                   empty_reg;

    // Result register.
    logic [CounterBits-1:0] out_count_reg;
    logic [CounterBits-1:0] out_same_cnt_reg;
    logic [RateBits-1:0]    out_syn_reg;
    logic [RateBits-1:0]    out_rej_reg;
    logic [RateBits-1:0]    out_same_reg;
    logic [RateBits-1:0]    out_diff_reg;
    logic                   out_empty_reg;

    hwts_pkg::div_ctrl_t    div_ctrl;
    logic [RateBits-1:0]    syn_rate;
    logic [RateBits-1:0]    rej_rate;
    logic [RateBits-1:0]    same_rate;
    logic [CounterBits-1:0] den_sel;

    logic                   evt_take;
    logic                   res_load;
    logic                   mem_we;
    logic [IdxBits-1:0]     mem_waddr;
    logic [CounterBits-1:0] mem_wdata;
    logic [CounterBits-1:0] rd_upd;

    function automatic logic [CounterBits-1:0] sat_inc(input logic [CounterBits-1:0] v);
        sat_inc = (v == '1) ? v : v + CounterBits'(1);
    endfunction

    function automatic logic [CounterBits-1:0] floor_dec(input logic [CounterBits-1:0] v);
        floor_dec = (v == '0) ? v : v - CounterBits'(1);
    endfunction

    assign evt.ready = (state_reg == hwts_pkg::S_IDLE);
    assign evt_take  = evt.valid && evt.ready;

    // Load the result register once the previous result has gone or is going.
    assign res_load  = (state_reg == hwts_pkg::S_FIN) && (!res_valid_reg || res.ready);

    assign rd_upd    = cmd_reg ? floor_dec(rd_reg) : sat_inc(rd_reg);
    assign mem_we    = (state_reg == hwts_pkg::S_CLEAR) || (state_reg == hwts_pkg::S_CALC);
    assign mem_waddr = (state_reg == hwts_pkg::S_CLEAR) ? clr_reg : idx_reg;
    assign mem_wdata = (state_reg == hwts_pkg::S_CLEAR) ? '0 : rd_upd;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        step_next      = step_reg;
        total_next     = total_reg;
        syn_cnt_next   = syn_cnt_reg;
        rej_cnt_next   = rej_cnt_reg;
        div_ctrl       = '0;
        res_valid_next = res_valid_reg;

        if (res.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            hwts_pkg::S_CLEAR:
            begin
                // Sweep the service memory to zero after reset.
                clr_next = clr_reg + IdxBits'(1);
                if (clr_reg == LastIdx)
                begin
                    state_next = hwts_pkg::S_IDLE;
                end
            end
            hwts_pkg::S_IDLE:
            begin
                if (evt_take)
                begin
                    state_next = hwts_pkg::S_READ;
                end
            end
            hwts_pkg::S_READ:
            begin
                state_next = hwts_pkg::S_CALC;
            end
            hwts_pkg::S_CALC:
            begin
                // Dividers sample the counters before this update.
                div_ctrl.start = 1'b1;
                step_next      = '0;
                if (cmd_reg)
                begin
                    total_next   = floor_dec(total_reg);
                    syn_cnt_next = syn_reg ? floor_dec(syn_cnt_reg) : syn_cnt_reg;
                    rej_cnt_next = rej_reg ? floor_dec(rej_cnt_reg) : rej_cnt_reg;
                    state_next   = hwts_pkg::S_FIN;
                end
                else
                begin
                    total_next   = sat_inc(total_reg);
                    syn_cnt_next = syn_reg ? sat_inc(syn_cnt_reg) : syn_cnt_reg;
                    rej_cnt_next = rej_reg ? sat_inc(rej_cnt_reg) : rej_cnt_reg;
                    state_next   = hwts_pkg::S_DIV;
                end
            end
            hwts_pkg::S_DIV:
            begin
                div_ctrl.step = 1'b1;
                step_next     = step_reg + StepBits'(1);
                if (step_reg == LastStep)
                begin
                    state_next = hwts_pkg::S_FIN;
                end
            end
            hwts_pkg::S_FIN:
            begin
                if (res_load)
                begin
                    res_valid_next = 1'b1;
                    state_next     = hwts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hwts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hwts_pkg::S_CLEAR;
            clr_reg       <= '0;
            step_reg      <= '0;
            total_reg     <= '0;
            syn_cnt_reg   <= '0;
            rej_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            step_reg      <= step_next;
            total_reg     <= total_next;
            syn_cnt_reg   <= syn_cnt_next;
            rej_cnt_reg   <= rej_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Service memory: one write port, registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            svc_mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == hwts_pkg::S_READ)
        begin
            rd_reg <= svc_mem[idx_reg];
        end
    end

    // Capture the request, the pre-update total and the post-update empty flag.
    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            cmd_reg <= evt.cmd;
            syn_reg <= evt.syn_error;
            rej_reg <= evt.rej_error;
            idx_reg <= wrap_tab[evt.service];
        end
        if (state_reg == hwts_pkg::S_CALC)
        begin
            den_reg   <= total_reg;
            empty_reg <= (total_next == '0);
        end
    end

    // All lanes start in the cycle that updates the total, so they divide by
    // the live total at start and by the snapshot afterward.
    assign den_sel = div_ctrl.start ? total_reg : den_reg;

    hwts_div #(.CounterBits(CounterBits), .FractionBits(FractionBits)) u_div_syn (
        .clk  (clk),
        .ctrl (div_ctrl),
        .num  (syn_cnt_reg),
        .den  (den_sel),
        .rate (syn_rate)
    );

    hwts_div #(.CounterBits(CounterBits), .FractionBits(FractionBits)) u_div_rej (
        .clk  (clk),
        .ctrl (div_ctrl),
        .num  (rej_cnt_reg),
        .den  (den_sel),
        .rate (rej_rate)
    );

    hwts_div #(.CounterBits(CounterBits), .FractionBits(FractionBits)) u_div_same (
        .clk  (clk),
        .ctrl (div_ctrl),
        .num  (rd_reg),
        .den  (den_sel),
        .rate (same_rate)
    );

    // Remove requests and adds to a window that was empty report zero for every rate.
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_empty_reg <= empty_reg;
            if (cmd_reg)
            begin
                out_count_reg    <= '0;
                out_same_cnt_reg <= '0;
                out_syn_reg      <= '0;
                out_rej_reg      <= '0;
                out_same_reg     <= '0;
                out_diff_reg     <= '0;
            end
            else
            begin
                out_count_reg    <= den_reg;
                out_same_cnt_reg <= rd_reg;
                if (den_reg == '0)
                begin
                    out_syn_reg  <= '0;
                    out_rej_reg  <= '0;
                    out_same_reg <= '0;
                    out_diff_reg <= '0;
                end
                else
                begin
                    out_syn_reg  <= syn_rate;
                    out_rej_reg  <= rej_rate;
                    out_same_reg <= same_rate;
                    out_diff_reg <= RateOne - same_rate;
                end
            end
        end
    end

    assign res.valid              = res_valid_reg;
    assign res.count_before       = out_count_reg;
    assign res.syn_error_rate     = out_syn_reg;
    assign res.rej_error_rate     = out_rej_reg;
    assign res.same_service_rate  = out_same_reg;
    assign res.diff_service_rate  = out_diff_reg;
    assign res.same_service_count = out_same_cnt_reg;
    assign res.window_empty       = out_empty_reg;

endmodule

// ===== src/hwts_checker.sv =====
// Port-level checker for the host window traffic stats core, with its bind.
// Depends on assert_macros.svh and hwts_pkg.
`include "assert_macros.svh"

module hwts_checker #(
    parameter int CounterBits  = hwts_pkg::COUNTER_BITS_DEF,
    parameter int FractionBits = hwts_pkg::FRACTION_BITS_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   evt_valid,
    input logic                   evt_ready,
    input logic                   res_valid,
    input logic                   res_ready,
    input logic [CounterBits-1:0] res_count_before,
    input logic [FractionBits:0]  res_syn_error_rate,
    input logic [FractionBits:0]  res_rej_error_rate,
    input logic [FractionBits:0]  res_same_service_rate,
    input logic [FractionBits:0]  res_diff_service_rate,
    input logic                   res_window_empty
);

    localparam logic [FractionBits+1:0] SumOne = (FractionBits + 2)'(1) << FractionBits;

    logic [1:0]              pend_reg, pend_next;
    logic [FractionBits+1:0] rate_sum;

    // Track requests taken whose results have not yet been delivered.
    always_comb
    begin
        pend_next = pend_reg;
        if ((evt_valid && evt_ready) && !(res_valid && res_ready))
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!(evt_valid && evt_ready) && (res_valid && res_ready))
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    assign rate_sum = {1'b0, res_same_service_rate} + {1'b0, res_diff_service_rate};

    `ASSERT_IMPLY(a_result_has_request, clk, rst_n, res_valid, (pend_reg != 2'd0),
        "result shown with no outstanding request")

    `ASSERT_IMPLY(a_rates_complement, clk, rst_n, (res_valid && (res_count_before != '0)),
        (rate_sum == SumOne), "same and different service rates do not sum to one")

    `ASSERT_IMPLY(a_empty_rates_zero, clk, rst_n, (res_valid && (res_count_before == '0)),
        ((res_syn_error_rate == '0) && (res_rej_error_rate == '0) && (rate_sum == '0)),
        "nonzero rate reported for an empty window")

    `ASSERT_NEXT(a_result_holds, clk, rst_n, (res_valid && !res_ready),
        (res_valid && $stable(res_count_before) && $stable(res_window_empty)),
        "stalled result changed")

endmodule

bind host_window_traffic_stats_core hwts_checker #(
    .CounterBits  (CounterBits),
    .FractionBits (FractionBits)
) u_hwts_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .evt_valid             (evt.valid),
    .evt_ready             (evt.ready),
    .res_valid             (res.valid),
    .res_ready             (res.ready),
    .res_count_before      (res.count_before),
    .res_syn_error_rate    (res.syn_error_rate),
    .res_rej_error_rate    (res.rej_error_rate),
    .res_same_service_rate (res.same_service_rate),
    .res_diff_service_rate (res.diff_service_rate),
    .res_window_empty      (res.window_empty)
);

// ===== bench/host_window_traffic_stats_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for host_window_traffic_stats_core at its default sizes.
// Depends on hwts_pkg, hwts_if and the core; a scoreboard class predicts each result.
module host_window_traffic_stats_core_tb;

    localparam int SVC_COUNT = hwts_pkg::SERVICE_COUNT_DEF;
    localparam int CNT_W     = hwts_pkg::COUNTER_BITS_DEF;
    localparam int FRAC_W    = hwts_pkg::FRACTION_BITS_DEF;
    localparam int SVC_W     = hwts_pkg::SERVICE_BITS;
    localparam int SVC_SPAN  = hwts_pkg::SERVICE_SPAN;

    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [FRAC_W:0]  RATE_ONE = {1'b1, {FRAC_W{1'b0}}};

    // Request command codes.
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] count_before;
        logic [FRAC_W:0]  syn_rate;
        logic [FRAC_W:0]  rej_rate;
        logic [FRAC_W:0]  same_rate;
        logic [FRAC_W:0]  diff_rate;
        logic [CNT_W-1:0] same_count;
        logic             window_empty;
    } host_stats_t;

    // One connection held open in the bench's own view of the window.
    typedef struct packed {
        logic [SVC_W-1:0] svc;
        logic             syn;
        logic             rej;
    } conn_t;

    // Scoreboard: mirror the host counters, queue the stats each request should
    // produce and compare every delivered result against the oldest of them.
    class host_window_predictor;
        logic [CNT_W-1:0] total_conns;
        logic [CNT_W-1:0] syn_conns;
        logic [CNT_W-1:0] rej_conns;
        logic [CNT_W-1:0] conns_per_service [SVC_COUNT];
        host_stats_t      expected_stats [$];
        int               mismatches;
        int               adds_seen;
        int               removes_seen;
        int               results_checked;
        int               empty_results;
        int               full_windows;

        function new();
            total_conns = '0;
            syn_conns   = '0;
            rej_conns   = '0;
            foreach (conns_per_service[i])
                conns_per_service[i] = '0;
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
            return (v == CNT_MAX) ? v : v + CNT_W'(1);
        endfunction

        function logic [CNT_W-1:0] drop(logic [CNT_W-1:0] v);
            return (v == '0) ? v : v - CNT_W'(1);
        endfunction

        // Truncated Q1.F quotient, clamped at one.
        function logic [FRAC_W:0] rate_of(logic [CNT_W-1:0] num, logic [CNT_W-1:0] den);
            logic [63:0] q;
            if (den == '0)
                return '0;
            q = (64'(num) << FRAC_W) / 64'(den);
            if (q > 64'(RATE_ONE))
                q = 64'(RATE_ONE);
            return q[FRAC_W:0];
        endfunction

        function void note_request(logic cmd, logic [SVC_W-1:0] svc, logic syn,
                                   logic rej);
            host_stats_t want;
            int          idx;
            idx  = int'(svc) % SVC_COUNT;
            want = '0;
            if (cmd == CMD_ADD)
            begin
                adds_seen++;
                // Report from the state before the add, then count it in.
                want.count_before = total_conns;
                want.same_count   = conns_per_service[idx];
                if (total_conns != '0)
                begin
                    want.syn_rate  = rate_of(syn_conns, total_conns);
                    want.rej_rate  = rate_of(rej_conns, total_conns);
                    want.same_rate = rate_of(conns_per_service[idx], total_conns);
                    want.diff_rate = RATE_ONE - want.same_rate;
                end
                total_conns = bump(total_conns);
                if (syn)
                    syn_conns = bump(syn_conns);
                if (rej)
                    rej_conns = bump(rej_conns);
                conns_per_service[idx] = bump(conns_per_service[idx]);
            end
            else
            begin
                removes_seen++;
                // Each counter stops at zero on its own.
                total_conns = drop(total_conns);
                if (syn)
                    syn_conns = drop(syn_conns);
                if (rej)
                    rej_conns = drop(rej_conns);
                conns_per_service[idx] = drop(conns_per_service[idx]);
            end
            want.window_empty = (total_conns == '0);
            if (total_conns == CNT_MAX)
                full_windows++;
            expected_stats.push_back(want);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch %0d: %s", $time, mismatches, what);
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                          results_checked, name, got, want));
        endtask

        task check_stats(host_stats_t got);
            host_stats_t want;
            if (expected_stats.size() == 0)
            begin
                report_mismatch("result delivered with no request waiting");
                return;
            end
            want = expected_stats.pop_front();
            results_checked++;
            if (want.window_empty)
                empty_results++;
            compare_field("count_before", 64'(got.count_before), 64'(want.count_before));
            compare_field("syn_error_rate", 64'(got.syn_rate), 64'(want.syn_rate));
            compare_field("rej_error_rate", 64'(got.rej_rate), 64'(want.rej_rate));
            compare_field("same_service_rate", 64'(got.same_rate), 64'(want.same_rate));
            compare_field("diff_service_rate", 64'(got.diff_rate), 64'(want.diff_rate));
            compare_field("same_service_count", 64'(got.same_count),
                          64'(want.same_count));
            compare_field("window_empty", 64'(got.window_empty), 64'(want.window_empty));
        endtask

        function int outstanding();
            return expected_stats.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    hwts_evt_if evt_ch ();
    hwts_res_if res_ch ();

    host_window_traffic_stats_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch)
    );

    host_window_predictor host_model = new();

    // Upper bounds of the per-request idle draws; the stimulus changes them
    // per phase so that some stretches run with no idling at all.
    int gap_max;
    int stall_max;

    // Connections the random traffic currently holds open, oldest first.
    conn_t open_conns [$];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop: far beyond the slowest correct run.
    initial
    begin
        #(2_000_000);
        $display("timeout: %0d results still outstanding", host_model.outstanding());
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one request: idle for a drawn number of cycles, present the
    // fields at a falling edge and hold them until the core takes them.
    task automatic send_request(input logic cmd, input logic [SVC_W-1:0] svc,
                                input logic syn, input logic rej);
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap > 0)
        begin
            @(negedge clk);
            evt_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        evt_ch.valid     <= 1'b1;
        evt_ch.cmd       <= cmd;
        evt_ch.service   <= svc;
        evt_ch.syn_error <= syn;
        evt_ch.rej_error <= rej;
        do
            @(posedge clk);
        while (!evt_ch.ready);
        host_model.note_request(cmd, svc, syn, rej);
    endtask

    // Mostly a handful of busy services, so same-service counts climb.
    function automatic logic [SVC_W-1:0] pick_service();
        case ($urandom_range(9, 0))
            0, 1:    return 7'd3;
            2:       return 7'd64;
            3:       return 7'd127;
            4, 5:    return 7'd17;
            default: return SVC_W'($urandom_range(SVC_SPAN - 1, 0));
        endcase
    endfunction

    task automatic open_conn();
        conn_t c;
        c.svc = pick_service();
        c.syn = ($urandom_range(3, 0) == 0);
        c.rej = ($urandom_range(4, 0) == 0);
        send_request(CMD_ADD, c.svc, c.syn, c.rej);
        open_conns.push_back(c);
    endtask

    // Retire the oldest open connection with its own fields, as a sliding
    // window would.
    task automatic close_oldest_conn();
        conn_t c;
        c = open_conns.pop_front();
        send_request(CMD_REMOVE, c.svc, c.syn, c.rej);
    endtask

    task automatic send_noise();
        send_request(1'($urandom_range(1, 0)), SVC_W'($urandom_range(SVC_SPAN - 1, 0)),
                     1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
    endtask

    // Result side: stall ready for a drawn number of cycles, then accept and
    // check the next result.
    initial
    begin
        int          stall;
        host_stats_t got;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(stall_max, 0);
            if (stall > 0)
            begin
                @(negedge clk);
                res_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            got.count_before = res_ch.count_before;
            got.syn_rate     = res_ch.syn_error_rate;
            got.rej_rate     = res_ch.rej_error_rate;
            got.same_rate    = res_ch.same_service_rate;
            got.diff_rate    = res_ch.diff_service_rate;
            got.same_count   = res_ch.same_service_count;
            got.window_empty = res_ch.window_empty;
            host_model.check_stats(got);
        end
    end

    initial
    begin
        int target;
        int pick;

        // Hold every input at a known value from time zero.
        rst_n            <= 1'b0;
        evt_ch.valid     <= 1'b0;
        evt_ch.cmd       <= CMD_ADD;
        evt_ch.service   <= '0;
        evt_ch.syn_error <= 1'b0;
        evt_ch.rej_error <= 1'b0;
        res_ch.ready     <= 1'b0;
        gap_max          = 3;
        stall_max        = 3;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: remove on an empty window, first add, field extremes.
        // The core clears its service memory first; the handshake absorbs it.
        send_request(CMD_REMOVE, 7'd0, 1'b1, 1'b1);
        send_request(CMD_ADD, 7'd0, 1'b0, 1'b0);
        send_request(CMD_ADD, 7'd127, 1'b1, 1'b1);
        send_request(CMD_ADD, 7'd127, 1'b1, 1'b0);
        send_request(CMD_ADD, 7'd64, 1'b0, 1'b1);
        send_request(CMD_REMOVE, 7'd127, 1'b1, 1'b1);
        send_request(CMD_ADD, 7'd127, 1'b0, 1'b0);
        // Remove on a service that was never counted: its counter stays at zero.
        send_request(CMD_REMOVE, 7'd5, 1'b1, 1'b1);
        send_request(CMD_REMOVE, 7'd0, 1'b0, 1'b0);
        // Drain past empty so the total, both error counters and service 127 sit at zero.
        repeat (5) send_request(CMD_REMOVE, 7'd127, 1'b1, 1'b1);
        send_request(CMD_ADD, 7'd85, 1'b0, 1'b1);
        send_request(CMD_REMOVE, 7'd85, 1'b0, 1'b1);
        // Unmatched remove leaves error and service counts above the total:
        // every rate clamps at one and the different-service rate reads zero.
        send_request(CMD_ADD, 7'd9, 1'b1, 1'b1);
        send_request(CMD_ADD, 7'd9, 1'b1, 1'b1);
        send_request(CMD_REMOVE, 7'd100, 1'b0, 1'b0);
        send_request(CMD_ADD, 7'd9, 1'b0, 1'b0);
        send_request(CMD_ADD, 7'd42, 1'b1, 1'b0);
        repeat (4) send_request(CMD_REMOVE, 7'd9, 1'b1, 1'b1);

        // Random: sliding-window traffic with matched removes, plus a share of
        // stray adds and unmatched removes. Some phases run with no idling.
        for (int phase = 0; phase < 7; phase++)
        begin
            gap_max   = (phase % 3 == 0) ? 0 : $urandom_range(6, 1);
            stall_max = (phase % 3 == 1) ? 0 : $urandom_range(6, 1);
            target    = (phase == 3) ? 0 : $urandom_range(24, 1);
            repeat (100)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 10)
                    send_noise();
                else if (open_conns.size() > target || (open_conns.size() > 0 && pick < 30))
                    close_oldest_conn();
                else
                    open_conn();
            end
        end
        while (open_conns.size() > 0)
            close_oldest_conn();

        // A few last requests under the longest idling.
        gap_max   = 6;
        stall_max = 6;
        send_request(CMD_ADD, 7'd42, 1'b0, 1'b0);
        send_request(CMD_ADD, 7'd1, 1'b1, 1'b1);
        send_request(CMD_REMOVE, 7'd1, 1'b0, 1'b0);
        send_request(CMD_ADD, 7'd42, 1'b1, 1'b0);

        @(negedge clk);
        evt_ch.valid <= 1'b0;

        // Wait for the last result, then give stray results time to surface.
        while (host_model.outstanding() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d adds and %0d removes, %0d results checked",
                 host_model.adds_seen, host_model.removes_seen, host_model.results_checked);
        $display("%0d results on an empty window, %0d requests with the window full",
                 host_model.empty_results, host_model.full_windows);
        if (host_model.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
